/* hw/rtl/cms_pkg.sv */
// Shared types, codes and hash constants for the count-min sketch table.
package cms_pkg;

    localparam int CMS_ROWS    = 4;
    localparam int CMS_COLUMNS = 1024;

    localparam int CMS_HASH_W  = 32;
    localparam int CMS_CNT_W   = 64;
    localparam int CMS_STEP_W  = $clog2(CMS_HASH_W);

    // bucket remainder steps: reciprocal multiply, subtract, correct
    localparam int CMS_MOD_STEPS = 3;

    // command field codes
    localparam logic CMD_READ   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // hash datapath operations
    typedef logic [2:0] t_hop;
    localparam t_hop HOP_XSM  = 3'd0;  // xor-shift then multiply
    localparam t_hop HOP_FIN16 = 3'd1; // xor with value shifted down 16
    localparam t_hop HOP_SIXA = 3'd2;  // first three add/xor steps
    localparam t_hop HOP_SIXB = 3'd3;  // last three add/xor steps
    localparam t_hop HOP_PMUL = 3'd4;  // xor-61 shift-add premix then multiply
    localparam t_hop HOP_FIN15 = 3'd5; // xor with value shifted down 15
    localparam t_hop HOP_MUL3 = 3'd6;  // plain multiplicative hash

    localparam logic [31:0] K_XSM  = 32'h045d_9f3b;
    localparam logic [31:0] K_S1   = 32'h7ed5_5d16;
    localparam logic [31:0] K_S2   = 32'hc761_c23c;
    localparam logic [31:0] K_S3   = 32'h1656_67b1;
    localparam logic [31:0] K_S4   = 32'hd3a2_646c;
    localparam logic [31:0] K_S5   = 32'hfd70_46c5;
    localparam logic [31:0] K_S6   = 32'hb55a_4f09;
    localparam logic [31:0] K_X61  = 32'd61;
    localparam logic [31:0] K_PMUL = 32'h27d4_eb2d;
    localparam logic [31:0] K_MUL3 = 32'd2654435761;

    typedef struct packed {
        t_hop op;
        logic last;
    } t_hash_step;

    typedef struct packed {
        logic clr;
        logic load;
        logic hash_en;
        t_hop op;
        logic mod_step;
        logic rd;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       row_oor;
        logic       is_read;
        logic       out_busy;
        logic [1:0] row;
    } t_dp_sts;

    // Hash program: operation for a given row and step, and whether it ends the hash.
    function automatic t_hash_step cms_hash_seq(input logic [1:0] row, input logic [1:0] step);
        t_hash_step s;
        s.op   = HOP_MUL3;
        s.last = 1'b1;
        case (row)
            2'd0: begin
                s.op   = (step == 2'd2) ? HOP_FIN16 : HOP_XSM;
                s.last = (step == 2'd2);
            end
            2'd1: begin
                s.op   = (step == 2'd0) ? HOP_SIXA : HOP_SIXB;
                s.last = (step != 2'd0);
            end
            2'd2: begin
                s.op   = (step == 2'd0) ? HOP_PMUL : HOP_FIN15;
                s.last = (step != 2'd0);
            end
            default: begin
                s.op   = HOP_MUL3;
                s.last = 1'b1;
            end
        endcase
        return s;
    endfunction

endpackage

/* hw/rtl/cms_if.sv */
// Valid/ready channel interfaces for sketch requests and read responses.
interface cms_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [1:0]  row;
    logic [31:0] flow_id;
    logic [63:0] value;

    modport source (output valid, command, row, flow_id, value, input ready);
    modport sink   (input valid, command, row, flow_id, value, output ready);
endinterface

interface cms_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] count;

    modport source (output valid, count, input ready);
    modport sink   (input valid, count, output ready);
endinterface

/* hw/rtl/count_min_sketch_table.sv */
// Top level of the count-min sketch table: controller plus datapath.
//
//  channel | dir | payload                                  | transfer when
//  i_req   | in  | command, row, flow_id, value             | i_req.valid & i_req.ready
//  o_rsp   | out | count (one per read, none per update)    | o_rsp.valid & o_rsp.ready
//
//  Flow: one item is in flight at a time. A request with a valid row passes
//  through accept, the row's hash program, the three-step reciprocal bucket
//  remainder (multiply, subtract, correct), a memory read and a finish. A row
//  beyond ROWS goes from the hash state straight to the finish state.
//  Reset: i_rst_n is synchronous; afterwards a clearing pass zeroes the memory,
//  one cell a cycle, all ROWS*COLUMNS cells (4096 by default), with i_req.ready low.
//  Stalls: the result register lets the next request in while a result waits;
//  a read finishing behind an untaken result holds until o_rsp takes it.
module count_min_sketch_table #(
    parameter int ROWS    = cms_pkg::CMS_ROWS,
    parameter int COLUMNS = cms_pkg::CMS_COLUMNS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cms_req_if.sink   i_req,
    cms_rsp_if.source o_rsp
);

    cms_pkg::t_dp_cmd w_cmd;
    cms_pkg::t_dp_sts w_sts;

    // sequence clearing, hashing, remainder and memory access
    cms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // hold the item, hash it, index the counter memory, drive the result
    cms_dp #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_command   (i_req.command),
        .i_row       (i_req.row),
        .i_flow_id   (i_req.flow_id),
        .i_value     (i_req.value),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_count     (o_rsp.count)
    );

endmodule

/* hw/rtl/cms_dp.sv */
// Sketch datapath: hash unit, reciprocal bucket remainder, counter memory, result register.
module cms_dp #(
    parameter int ROWS    = cms_pkg::CMS_ROWS,
    parameter int COLUMNS = cms_pkg::CMS_COLUMNS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cms_pkg::t_dp_cmd i_cmd,
    output cms_pkg::t_dp_sts o_sts,
    input  logic             i_command,
    input  logic [1:0]       i_row,
    input  logic [31:0]      i_flow_id,
    input  logic [63:0]      i_value,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [63:0]      o_count
);

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(COLUMNS);

    // floor(2^32 / COLUMNS): the quotient estimate is short by at most one
    localparam logic [31:0] COL_W = 32'(COLUMNS);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / COLUMNS);

    logic [63:0]   mem [DEPTH];

    logic          r_command;
    logic [1:0]    r_row;
    logic [63:0]   r_value;
    logic [31:0]   r_h, n_h;
    logic [31:0]   r_q, n_q;
    logic [31:0]   r_r, n_r;
    logic [BW-1:0] r_rem, n_rem;
    logic [63:0]   w_prod;
    logic [63:0]   r_rdata;
    logic [AW-1:0] r_clr_addr;
    logic          r_out_valid;
    logic [63:0]   r_count;
    logic [AW-1:0] w_addr;
    logic          w_oor;
    logic          w_wr;

    logic [31:0] x1, a1, a2, a3, b1, b2, b3, p1, p2, p3;

    // hash operations on the working word
    always_comb begin
        x1 = (r_h >> 16) ^ r_h;
        a1 = (r_h + cms_pkg::K_S1) + (r_h << 12);
        a2 = (a1 ^ cms_pkg::K_S2) ^ (a1 >> 19);
        a3 = (a2 + cms_pkg::K_S3) + (a2 << 5);
        b1 = (r_h + cms_pkg::K_S4) ^ (r_h << 9);
        b2 = (b1 + cms_pkg::K_S5) + (b1 << 3);
        b3 = (b2 ^ cms_pkg::K_S6) ^ (b2 >> 16);
        p1 = (r_h ^ cms_pkg::K_X61) ^ (r_h >> 16);
        p2 = p1 + (p1 << 3);
        p3 = p2 ^ (p2 >> 4);
        case (i_cmd.op)
            cms_pkg::HOP_XSM:   n_h = x1 * cms_pkg::K_XSM;
            cms_pkg::HOP_FIN16: n_h = x1;
            cms_pkg::HOP_SIXA:  n_h = a3;
            cms_pkg::HOP_SIXB:  n_h = b3;
            cms_pkg::HOP_PMUL:  n_h = p3 * cms_pkg::K_PMUL;
            cms_pkg::HOP_FIN15: n_h = r_h ^ (r_h >> 15);
            cms_pkg::HOP_MUL3:  n_h = r_h * cms_pkg::K_MUL3;
            default:            n_h = r_h;
        endcase
    end

    // three-stage remainder: estimate quotient, subtract, correct once
    always_comb begin
        w_prod = 64'(r_h) * 64'(RECIP);
        n_q    = w_prod[63:32];
        n_r    = r_h - r_q * COL_W;
        n_rem  = (r_r >= COL_W) ? BW'(r_r - COL_W) : BW'(r_r);
    end

    assign w_oor  = (int'(r_row) >= ROWS);
    assign w_addr = AW'(r_row * COLUMNS) + AW'(r_rem);
    assign w_wr   = i_cmd.finish && (r_command == cms_pkg::CMD_UPDATE) && !w_oor
                    && (r_value > r_rdata);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_row     <= i_row;
            r_value   <= i_value;
            r_h       <= i_flow_id;
            r_rem     <= '0;
        end else if (i_cmd.hash_en) begin
            r_h <= n_h;
        end else if (i_cmd.mod_step) begin
            r_q   <= n_q;
            r_r   <= n_r;
            r_rem <= n_rem;
        end
        if (i_cmd.finish && (r_command == cms_pkg::CMD_READ)) begin
            r_count <= w_oor ? '0 : r_rdata;
        end
    end

    // counter memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem[r_clr_addr] <= '0;
        end else if (w_wr) begin
            mem[w_addr] <= r_value;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.finish && (r_command == cms_pkg::CMD_READ)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.row_oor  = w_oor;
    assign o_sts.is_read  = (r_command == cms_pkg::CMD_READ);
    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_sts.row      = r_row;

    assign o_out_valid = r_out_valid;
    assign o_count     = r_count;

endmodule

/* hw/rtl/cms_ctrl.sv */
// Sketch controller: clearing pass, hash program, remainder count, memory access.
module cms_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cms_pkg::t_dp_sts i_sts,
    output cms_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam int SW = cms_pkg::CMS_STEP_W;
    localparam logic [SW-1:0] MOD_LAST = SW'(cms_pkg::CMS_MOD_STEPS - 1);

    logic [2:0]          r_state, n_state;
    logic [SW-1:0]       r_cnt, n_cnt;
    cms_pkg::t_hash_step w_seq;

    assign w_seq = cms_pkg::cms_hash_seq(i_sts.row, r_cnt[1:0]);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_HASH;
                end
            end
            ST_HASH: begin
                if (i_sts.row_oor) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.hash_en = 1'b1;
                    o_cmd.op      = w_seq.op;
                    if (w_seq.last) begin
                        n_cnt   = '0;
                        n_state = ST_MOD;
                    end else begin
                        n_cnt = r_cnt + SW'(1);
                    end
                end
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_cnt          = r_cnt + SW'(1);
                if (r_cnt == MOD_LAST) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                // hold a read while the previous result is still waiting
                if (!(i_sts.is_read && i_sts.out_busy)) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* hw/rtl/cms_chk.sv */
// Port-level checks for the count-min sketch table, bound to the top level.
module cms_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [63:0] i_rsp_count
);

    logic w_req_xfer;
    assign w_req_xfer = i_req_valid && i_req_ready;

    // one request in flight: no new transfer right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_xfer |=> !i_req_ready)
        else $error("request taken while previous one in flight");

    // a result cannot appear in the cycle right after its request
    a_no_early_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_xfer |=> !$rose(i_rsp_valid))
        else $error("response too early after request");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("response dropped before transfer");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> $stable(i_rsp_count))
        else $error("stalled response count changed");

endmodule

bind count_min_sketch_table cms_chk u_cms_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_count (o_rsp.count)
);
